[rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int PRIO_W   = 32;
    localparam int HANDLE_W = 16;
    localparam int OCC_W    = 5;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic                     in_kind;
        logic signed [PRIO_W-1:0] in_priority;
        logic [HANDLE_W-1:0]      in_handle;
    } req_t;

    typedef struct packed {
        logic                     pop_valid;
        logic                     out_kind;
        logic signed [PRIO_W-1:0] out_priority;
        logic [HANDLE_W-1:0]      out_handle;
        logic                     push_rejected;
        logic [OCC_W-1:0]         occupancy;
    } rsp_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

[rtl/sorted_priority_queue.sv]
// Sorted priority queue: top level with the cell chain, count and result register.
// Depends on spq_pkg and spq_cell.
//
// Usage: each request word on req is either a push (kind, priority, handle)
// or a pop. Entries sit in a row of QUEUE_DEPTH cells in descending priority;
// every cell compares its own priority with the pushed one in the same cycle,
// so the insertion point is found in parallel and the row shifts by one place.
// Among equal priorities the newest entry leaves first. A push into a full
// queue is dropped and flagged by push_rejected; a pop of an empty queue
// returns pop_valid 0 with zero fields.
// Every request gives one response word on rsp, registered: it shows rsp_valid
// in the cycle after acceptance. One request is taken per cycle while req_stall
// is low; the chain shift and count update are registered with the response.
// When the receiver stalls, the response word holds and req_stall rises once
// a finished word waits, so no new request is taken until the word leaves.
// Reset empties the queue (count zero) and clears rsp_valid; cell contents
// are not cleared and are never read before being written.
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    localparam int HB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          accept;
    logic          full;
    logic          empty;
    cell_ctl_t     ctl;

    logic                     new_kind;
    logic signed [PRIO_W-1:0] new_prio;
    logic [HB-1:0]            new_handle;

    logic                     le_v     [QUEUE_DEPTH];
    logic                     kind_v   [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] prio_v   [QUEUE_DEPTH];
    logic [HB-1:0]            handle_v [QUEUE_DEPTH];

    logic [31:0] count_ext;
    logic [31:0] count_reg_ext;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    assign new_kind   = req.in_kind;
    assign new_prio   = req.in_priority;
    assign new_handle = req.in_handle[HB-1:0];

    assign ctl.push = accept && (req.opcode == OP_PUSH) && !full;
    assign ctl.pop  = accept && (req.opcode == OP_POP) && !empty;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic                     l_le;
            logic                     l_kind;
            logic signed [PRIO_W-1:0] l_prio;
            logic [HB-1:0]            l_handle;
            logic                     r_kind;
            logic signed [PRIO_W-1:0] r_prio;
            logic [HB-1:0]            r_handle;
            logic                     occ;

            if (g == 0)
            begin : g_head
                assign l_le     = 1'b0;
                assign l_kind   = new_kind;
                assign l_prio   = new_prio;
                assign l_handle = new_handle;
            end
            else
            begin : g_body
                assign l_le     = le_v[g-1];
                assign l_kind   = kind_v[g-1];
                assign l_prio   = prio_v[g-1];
                assign l_handle = handle_v[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_kind   = 1'b0;
                assign r_prio   = '0;
                assign r_handle = '0;
            end
            else
            begin : g_inner
                assign r_kind   = kind_v[g+1];
                assign r_prio   = prio_v[g+1];
                assign r_handle = handle_v[g+1];
            end

            assign occ = (CW'(g) < count_reg);

            spq_cell #(
                .HB (HB)
            ) u_cell (
                .clk          (clk),
                .ctl          (ctl),
                .occupied     (occ),
                .new_kind     (new_kind),
                .new_prio     (new_prio),
                .new_handle   (new_handle),
                .left_le      (l_le),
                .left_kind    (l_kind),
                .left_prio    (l_prio),
                .left_handle  (l_handle),
                .right_kind   (r_kind),
                .right_prio   (r_prio),
                .right_handle (r_handle),
                .le           (le_v[g]),
                .kind         (kind_v[g]),
                .prio         (prio_v[g]),
                .handle       (handle_v[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_ext     = 32'(count_next);
    assign count_reg_ext = 32'(count_reg);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.pop_valid     = ctl.pop;
            rsp_next.out_kind      = ctl.pop ? kind_v[0] : 1'b0;
            rsp_next.out_priority  = ctl.pop ? prio_v[0] : '0;
            rsp_next.out_handle    = ctl.pop ? HANDLE_W'(handle_v[0]) : '0;
            rsp_next.push_rejected = (req.opcode == OP_PUSH) && full;
            rsp_next.occupancy     = count_ext[OCC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.opcode == OP_PUSH) && full |=> rsp_valid && rsp.push_rejected)
        else $error("push into full queue not rejected");

    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.occupancy == count_reg_ext[OCC_W-1:0])
        else $error("reported occupancy differs from count");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.opcode == OP_POP) && empty |=> rsp_valid && !rsp.pop_valid)
        else $error("pop of empty queue returned an entry");

endmodule

[rtl/spq_cell.sv]
// One slot of the sorted chain: holds one entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell #(
    parameter int HB = spq_pkg::HANDLE_W
) (
    input  logic                              clk,
    input  spq_pkg::cell_ctl_t                ctl,
    input  logic                              occupied,
    input  logic                              new_kind,
    input  logic signed [spq_pkg::PRIO_W-1:0] new_prio,
    input  logic [HB-1:0]                     new_handle,
    input  logic                              left_le,
    input  logic                              left_kind,
    input  logic signed [spq_pkg::PRIO_W-1:0] left_prio,
    input  logic [HB-1:0]                     left_handle,
    input  logic                              right_kind,
    input  logic signed [spq_pkg::PRIO_W-1:0] right_prio,
    input  logic [HB-1:0]                     right_handle,
    output logic                              le,
    output logic                              kind,
    output logic signed [spq_pkg::PRIO_W-1:0] prio,
    output logic [HB-1:0]                     handle
);
    import spq_pkg::*;

    logic                     kind_reg, kind_next;
    logic signed [PRIO_W-1:0] prio_reg, prio_next;
    logic [HB-1:0]            handle_reg, handle_next;

    // An empty slot counts as lower than any new entry.
    assign le = !occupied || (prio_reg <= new_prio);

    always_comb
    begin
        kind_next   = kind_reg;
        prio_next   = prio_reg;
        handle_next = handle_reg;
        if (ctl.push)
        begin
            if (left_le)
            begin
                // shift right to open the gap
                kind_next   = left_kind;
                prio_next   = left_prio;
                handle_next = left_handle;
            end
            else if (le)
            begin
                kind_next   = new_kind;
                prio_next   = new_prio;
                handle_next = new_handle;
            end
        end
        else if (ctl.pop)
        begin
            kind_next   = right_kind;
            prio_next   = right_prio;
            handle_next = right_handle;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        prio_reg   <= prio_next;
        handle_reg <= handle_next;
    end

    assign kind   = kind_reg;
    assign prio   = prio_reg;
    assign handle = handle_reg;

endmodule
